// ===== rtl/element_jacobian_determinant_defines.svh =====
// -----------------------------------------------------------------------------
// element_jacobian_determinant_defines
// Assertion macros shared by the element Jacobian determinant RTL.
// -----------------------------------------------------------------------------
`ifndef ELEMENT_JACOBIAN_DETERMINANT_DEFINES_SVH
`define ELEMENT_JACOBIAN_DETERMINANT_DEFINES_SVH

// Plain property, clocked on clk_i, off during reset.
`define EJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, clocked on clk_i, off during reset.
`define EJD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ejd_pkg.sv =====
// -----------------------------------------------------------------------------
// ejd_pkg
// Types, constants and small tables of the element Jacobian determinant.
// -----------------------------------------------------------------------------
package ejd_pkg;

  localparam int MaxVerticesDef = 8;
  localparam int FracBitsDef    = 16;

  // Multiplier operand width (signed) and product width
  localparam int MulW  = 33;
  localparam int ProdW = 2 * MulW;
  // Determinant accumulator width (Q.48, bounded by six 96-bit terms)
  localparam int DetW  = 98;

  // Element types
  localparam logic [1:0] ModeHex     = 2'd0;
  localparam logic [1:0] ModePrism   = 2'd1;
  localparam logic [1:0] ModePyramid = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAD,
    S_ACC,
    S_JAC,
    S_DET,
    S_ROUND
  } state_e;

  // How one vertex forms its gradient
  typedef enum logic [1:0] {
    K_NONE,
    K_HEX,
    K_EDGE,
    K_APEX
  } kind_e;

  // Vertices per element type
  function automatic logic [3:0] vertex_count(input logic [1:0] mode);
    unique case (mode)
      ModeHex:     vertex_count = 4'd8;
      ModePrism:   vertex_count = 4'd6;
      ModePyramid: vertex_count = 4'd5;
      default:     vertex_count = 4'd0;
    endcase
  endfunction

  // Hexahedron corner of a prism vertex (edges unused)
  function automatic logic [2:0] prism_corner(input logic [2:0] v);
    unique case (v)
      3'd2:    prism_corner = 3'd1;
      3'd4:    prism_corner = 3'd3;
      3'd5:    prism_corner = 3'd2;
      default: prism_corner = 3'd0;
    endcase
  endfunction

  // Determinant terms with a minus sign
  function automatic logic term_neg(input logic [3:0] t);
    term_neg = (t == 4'd1) || (t == 4'd2) || (t == 4'd5);
  endfunction

endpackage

// ===== rtl/element_jacobian_determinant.sv =====
// -----------------------------------------------------------------------------
// element_jacobian_determinant
// Jacobian determinant of a hexahedron, prism or pyramid element at one
// reference point, built around one shared 33x33 multiplier.
// -----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i / in_stall_o): one transfer per element vertex,
//   carrying mode, vertex index, reference point and vertex coordinates.
//   last_vertex_i marks the final vertex of the element.
// - Output channel (out_valid_o / out_stall_i): one transfer per element with
//   the Q32.32 determinant and the saturation flag.
// - Each vertex keeps the block busy after its transfer for 3 gradient and 9
//   accumulate multiplies, each issued and then used as a registered product
//   on the single shared multiplier.
// - A last vertex then rounds the nine Jacobian entries, runs six determinant
//   terms of three multiplies each and rounds once more before the result
//   shows at out_valid_o.
// - A finished result waits in the output register while new vertices are
//   taken; only the final rounding step waits if the register is still full.
// - Reset clears the nine Jacobian sums and empties the output register.
// -----------------------------------------------------------------------------
module element_jacobian_determinant #(
  parameter int MAX_VERTICES = ejd_pkg::MaxVerticesDef,
  parameter int FRAC_BITS    = ejd_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         vertex_index_i,
  input  logic signed [17:0] eta_one_i,
  input  logic signed [17:0] eta_two_i,
  input  logic signed [17:0] eta_three_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic               last_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] determinant_o,
  output logic               saturated_o
);
  import ejd_pkg::*;

  `include "element_jacobian_determinant_defines.svh"

  // Internal eta width and shape-factor width
  localparam int EW = (FRAC_BITS >= 16) ? FRAC_BITS + 2 : 18;
  localparam int FW = EW + 1;
  localparam int JW = 65 - FRAC_BITS;
  localparam logic signed [FW-1:0] ONE_F  = FW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [MulW-1:0] HALF_G = MulW'(64'sd1 <<< (FRAC_BITS - 1));

  // Control state
  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       phase_q, phase_d;
  logic [1:0] sub_q, sub_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer, out_xfer, out_load;

  // Captured vertex
  logic [1:0]         mode_q;
  logic [2:0]         vtx_q;
  logic signed [17:0] eta_q [3];
  logic signed [31:0] crd_q [3];
  logic               last_q;

  // Datapath
  logic signed [ProdW-1:0] p_q;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [MulW-1:0]  g_q [3];
  logic [63:0]             sums_q [9];
  logic signed [31:0]      j_q [9];
  logic [63:0]             hold_q;
  logic signed [DetW-1:0]  acc_q;
  logic                    sat_q;
  logic signed [63:0]      det_q;
  logic                    det_sat_q;

  // ---------------------------------------------------------------------------
  // Eta in FRAC_BITS fraction bits
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0] e_int [3];

  for (genvar k = 0; k < 3; k++) begin : g_eta
    if (FRAC_BITS >= 16) begin : g_up
      assign e_int[k] = EW'(eta_q[k]) <<< (FRAC_BITS - 16);
    end else begin : g_dn
      localparam int SH = 16 - FRAC_BITS;
      assign e_int[k] = EW'(eta_q[k] >>> SH) + EW'($signed({1'b0, eta_q[k][SH-1]}));
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex classification and shape factors
  // ---------------------------------------------------------------------------
  kind_e      kind;
  logic [2:0] corner;
  logic signed [FW-1:0] f [3];

  always_comb begin
    kind   = K_NONE;
    corner = vtx_q;
    if ((4'(vtx_q) < vertex_count(mode_q)) && (32'(vtx_q) < 32'(MAX_VERTICES))) begin
      unique case (mode_q)
        ModeHex: kind = K_HEX;
        ModePrism: begin
          if ((vtx_q == 3'd0) || (vtx_q == 3'd3)) begin
            kind = K_EDGE;
          end else begin
            kind   = K_HEX;
            corner = prism_corner(vtx_q);
          end
        end
        ModePyramid: kind = (vtx_q < 3'd4) ? K_HEX : K_APEX;
        default: kind = K_NONE;
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      f[k] = ONE_F + (corner[k] ? FW'(e_int[k]) : -FW'(e_int[k]));
    end
  end

  // Collapsed prism edge gradients (s2 = +1 on vertex 3)
  logic signed [FW-1:0]   edge_t1, edge_t2;
  logic signed [MulW-1:0] edge_g1, edge_g2;

  always_comb begin
    edge_t1 = ONE_F + FW'(e_int[2]);
    if (vtx_q != 3'd3) edge_t1 = -edge_t1;
    edge_t2 = ONE_F + ((vtx_q == 3'd3) ? FW'(e_int[1]) : -FW'(e_int[1]));
    edge_g1 = MulW'(edge_t1 >>> 2) + MulW'($signed({1'b0, edge_t1[1]}));
    edge_g2 = MulW'(edge_t2 >>> 2) + MulW'($signed({1'b0, edge_t2[1]}));
  end

  // Gradient component for the current step from the registered product
  logic signed [ProdW-1:0] p_sgn;
  logic signed [MulW-1:0]  g_new;

  always_comb begin
    p_sgn = corner[step_q[1:0]] ? p_q : -p_q;
    g_new = '0;
    unique case (kind)
      K_HEX: g_new = MulW'(p_sgn >>> (FRAC_BITS + 3)) +
                     MulW'($signed({1'b0, p_sgn[FRAC_BITS+2]}));
      K_EDGE: begin
        if (step_q == 4'd1) g_new = edge_g1;
        if (step_q == 4'd2) g_new = edge_g2;
      end
      K_APEX: if (step_q == 4'd2) g_new = HALF_G;
      default: g_new = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Jacobian entry rounding and saturation
  // ---------------------------------------------------------------------------
  logic [63:0]          sum_sel;
  logic signed [JW-1:0] j_wide;
  logic signed [31:0]   j_new;
  logic                 j_sat;

  always_comb begin
    sum_sel = sums_q[step_q];
    j_wide  = JW'($signed(sum_sel) >>> FRAC_BITS) +
              JW'($signed({1'b0, sum_sel[FRAC_BITS-1]}));
    j_sat   = 1'b1;
    if (j_wide > JW'(64'sd2147483647)) begin
      j_new = 32'sh7FFF_FFFF;
    end else if (j_wide < JW'(-64'sd2147483648)) begin
      j_new = 32'sh8000_0000;
    end else begin
      j_new = j_wide[31:0];
      j_sat = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Determinant rounding to Q32.32 and saturation
  // ---------------------------------------------------------------------------
  logic signed [DetW-1:0] acc_rnd, acc_sh;
  logic                   det_fits;
  logic signed [63:0]     det_new;

  always_comb begin
    acc_rnd  = acc_q + DetW'(64'sd32768);
    acc_sh   = acc_rnd >>> 16;
    det_fits = (&acc_sh[DetW-1:63]) || !(|acc_sh[DetW-1:63]);
    if (det_fits) det_new = acc_sh[63:0];
    else          det_new = acc_sh[DetW-1] ? 64'sh8000_0000_0000_0000
                                           : 64'sh7FFF_FFFF_FFFF_FFFF;
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  logic signed [31:0] ja, jb, jc;

  always_comb begin
    unique case (step_q)
      4'd0:    begin ja = j_q[0]; jb = j_q[4]; jc = j_q[8]; end
      4'd1:    begin ja = j_q[0]; jb = j_q[5]; jc = j_q[7]; end
      4'd2:    begin ja = j_q[1]; jb = j_q[3]; jc = j_q[8]; end
      4'd3:    begin ja = j_q[1]; jb = j_q[5]; jc = j_q[6]; end
      4'd4:    begin ja = j_q[2]; jb = j_q[3]; jc = j_q[7]; end
      default: begin ja = j_q[2]; jb = j_q[4]; jc = j_q[6]; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_GRAD: begin
        unique case (step_q)
          4'd0:    begin mul_a = MulW'(f[1]); mul_b = MulW'(f[2]); end
          4'd1:    begin mul_a = MulW'(f[0]); mul_b = MulW'(f[2]); end
          default: begin mul_a = MulW'(f[0]); mul_b = MulW'(f[1]); end
        endcase
      end
      S_ACC: begin
        // entry 3*r+d: gradient d times coordinate r
        unique case (step_q)
          4'd0, 4'd3, 4'd6: mul_a = g_q[0];
          4'd1, 4'd4, 4'd7: mul_a = g_q[1];
          default:          mul_a = g_q[2];
        endcase
        if (step_q < 4'd3)      mul_b = MulW'(crd_q[0]);
        else if (step_q < 4'd6) mul_b = MulW'(crd_q[1]);
        else                    mul_b = MulW'(crd_q[2]);
      end
      S_DET: begin
        unique case (sub_q)
          2'd0:    begin mul_a = MulW'(ja); mul_b = MulW'(jb); end
          2'd1:    begin mul_a = MulW'($signed(hold_q[63:32])); mul_b = MulW'(jc); end
          default: begin mul_a = $signed({1'b0, hold_q[31:0]}); mul_b = MulW'(jc); end
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and handshakes
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_ROUND) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    sub_d       = sub_q;
    out_valid_d = (out_valid_q && !out_xfer) || out_load;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_GRAD;
          step_d  = '0;
          phase_d = 1'b0;
        end
      end
      S_GRAD: begin
        phase_d = !phase_q;
        if (phase_q) begin
          if (step_q == 4'd2) begin
            state_d = S_ACC;
            step_d  = '0;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      S_ACC: begin
        phase_d = !phase_q;
        if (phase_q) begin
          if (step_q == 4'd8) begin
            state_d = last_q ? S_JAC : S_IDLE;
            step_d  = '0;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      S_JAC: begin
        if (step_q == 4'd8) begin
          state_d = S_DET;
          step_d  = '0;
          sub_d   = '0;
          phase_d = 1'b0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_DET: begin
        phase_d = !phase_q;
        if (phase_q) begin
          if (sub_q == 2'd2) begin
            sub_d = '0;
            if (step_q == 4'd5) state_d = S_ROUND;
            else                step_d  = step_q + 4'd1;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      S_ROUND: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      phase_q     <= 1'b0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Jacobian sums: cleared at reset and after each element
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) sums_q[i] <= '0;
    end else if (out_load) begin
      for (int i = 0; i < 9; i++) sums_q[i] <= '0;
    end else if ((state_q == S_ACC) && phase_q) begin
      sums_q[step_q] <= sums_q[step_q] + p_q[63:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (in_xfer) begin
      mode_q   <= mode_i;
      vtx_q    <= vertex_index_i;
      eta_q[0] <= eta_one_i;
      eta_q[1] <= eta_two_i;
      eta_q[2] <= eta_three_i;
      crd_q[0] <= coord_x_i;
      crd_q[1] <= coord_y_i;
      crd_q[2] <= coord_z_i;
      last_q   <= last_vertex_i;
    end
    if ((state_q == S_GRAD) && phase_q) g_q[step_q[1:0]] <= g_new;
    if (state_q == S_JAC) begin
      j_q[step_q] <= j_new;
      sat_q       <= ((step_q == 4'd0) ? 1'b0 : sat_q) | j_sat;
      acc_q       <= '0;
    end
    if ((state_q == S_DET) && phase_q) begin
      unique case (sub_q)
        2'd0: hold_q <= p_q[63:0];
        2'd1: acc_q  <= term_neg(step_q) ? acc_q - (DetW'(p_q) <<< 32)
                                         : acc_q + (DetW'(p_q) <<< 32);
        default: acc_q <= term_neg(step_q) ? acc_q - DetW'(p_q) : acc_q + DetW'(p_q);
      endcase
    end
    if (out_load) begin
      det_q     <= det_new;
      det_sat_q <= sat_q || !det_fits;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign determinant_o = det_q;
  assign saturated_o   = det_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `EJD_ASSERT_IMP(a_out_from_round, $rose(out_valid_q), $past(state_q) == S_ROUND,
                  "result appeared outside the rounding step")
  `EJD_ASSERT_IMP(a_sums_cleared, ($past(state_q) == S_ROUND) && (state_q == S_IDLE),
                  (sums_q[0] == 64'd0) && (sums_q[4] == 64'd0) && (sums_q[8] == 64'd0),
                  "Jacobian sums not cleared after an element")
  `EJD_ASSERT(a_accept_starts_grad, in_xfer |=> (state_q == S_GRAD) && (step_q == 4'd0),
              "vertex transfer did not start the gradient steps")

endmodule

// ===== tb/tb_element_jacobian_determinant.sv =====
// -----------------------------------------------------------------------------
// tb_element_jacobian_determinant
// Self-checking bench for the element Jacobian determinant. Elements of every
// type are sent vertex by vertex. A local model forms the gradients, the nine
// Jacobian sums and the rounded, saturated determinant, and every output
// transfer is checked against it in order.
// -----------------------------------------------------------------------------
module tb_element_jacobian_determinant;
  import ejd_pkg::*;

  localparam logic [1:0] ModeReserved = 2'd3;
  localparam int         QuietStart   = 6000;
  localparam int         QuietEnd     = 10000;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         vtx;
    logic signed [17:0] e1, e2, e3;
    logic signed [31:0] cx, cy, cz;
    logic               last;
    bit                 drain;
  } vertex_t;

  typedef struct {
    logic signed [63:0] det;
    logic               sat;
  } det_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic [2:0]         vertex_index_i = '0;
  logic signed [17:0] eta_one_i = '0, eta_two_i = '0, eta_three_i = '0;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic               last_vertex_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [63:0] determinant_o;
  logic               saturated_o;

  element_jacobian_determinant DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vertex_t     vertex_q[$];
  det_result_t det_q[$];
  vertex_t     cur_vertex;
  bit          taken = 1'b0;
  longint      jac_sums[9];
  int          mismatches = 0;
  int          cyc = 0;
  int          n_items = 0;

  // Round half up on a right shift
  function automatic longint rnd_shift(longint x, int s);
    return (x >>> s) + ((x >>> (s - 1)) & 64'sd1);
  endfunction

  // Trilinear corner gradient, corner signs from the bits of n
  function automatic void hex_gradient(logic [2:0] n, longint e[3], output longint g[3]);
    longint s[3], f[3];
    for (int k = 0; k < 3; k++) begin
      s[k] = n[k] ? 64'sd1 : -64'sd1;
      f[k] = 64'sd65536 + s[k] * e[k];
    end
    g[0] = rnd_shift(s[0] * f[1] * f[2], 19);
    g[1] = rnd_shift(s[1] * f[0] * f[2], 19);
    g[2] = rnd_shift(s[2] * f[0] * f[1], 19);
  endfunction

  function automatic logic signed [127:0] triple(longint a, longint b, longint c);
    logic signed [127:0] p;
    p = a * b;
    return p * c;
  endfunction

  // Add one vertex into the sums; on the last one queue the determinant
  task automatic accumulate_vertex(vertex_t it);
    longint e[3], c[3], g[3], j[9], x;
    logic [2:0] corner[6];
    int cnt;
    logic signed [127:0] acc;
    det_result_t r;
    corner = '{3'd0, 3'd0, 3'd1, 3'd0, 3'd3, 3'd2};
    e[0] = it.e1; e[1] = it.e2; e[2] = it.e3;
    c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
    g = '{0, 0, 0};
    cnt = (it.mode == ModeHex) ? 8 : (it.mode == ModePrism) ? 6 :
          (it.mode == ModePyramid) ? 5 : 0;
    if (it.vtx < cnt) begin
      if (it.mode == ModeHex) begin
        hex_gradient(it.vtx, e, g);
      end else if (it.mode == ModePrism) begin
        if (it.vtx == 3'd0 || it.vtx == 3'd3) begin
          // collapsed edge
          x = (it.vtx == 3'd3) ? 64'sd1 : -64'sd1;
          g[1] = rnd_shift(x * (64'sd65536 + e[2]), 2);
          g[2] = rnd_shift(64'sd65536 + x * e[1], 2);
        end else begin
          hex_gradient(corner[it.vtx], e, g);
        end
      end else if (it.vtx < 3'd4) begin
        hex_gradient(it.vtx, e, g);
      end else begin
        g[2] = 64'sd32768;   // apex
      end
    end
    for (int rr = 0; rr < 3; rr++)
      for (int d = 0; d < 3; d++)
        jac_sums[3 * rr + d] += g[d] * c[rr];
    if (it.last) begin
      r.sat = 1'b0;
      for (int k = 0; k < 9; k++) begin
        x = rnd_shift(jac_sums[k], 16);
        if (x > 64'sd2147483647) begin x = 64'sd2147483647; r.sat = 1'b1; end
        if (x < -64'sd2147483648) begin x = -64'sd2147483648; r.sat = 1'b1; end
        j[k] = x;
      end
      acc = triple(j[0], j[4], j[8]) - triple(j[0], j[5], j[7])
          - triple(j[1], j[3], j[8]) + triple(j[1], j[5], j[6])
          + triple(j[2], j[3], j[7]) - triple(j[2], j[4], j[6]);
      acc = (acc + 128'sd32768) >>> 16;
      if ((&acc[127:63]) || !(|acc[127:63])) begin
        r.det = acc[63:0];
      end else begin
        r.sat = 1'b1;
        r.det = acc[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      det_q.push_back(r);
      jac_sums = '{default: 0};
    end
  endtask

  function automatic logic signed [31:0] rand_coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
  endfunction

  task automatic add_vertex(logic [1:0] m, logic [2:0] v, logic signed [17:0] a, b, c,
                            bit wide, logic last, bit drain);
    vertex_t it;
    it.mode = m; it.vtx = v; it.e1 = a; it.e2 = b; it.e3 = c;
    it.cx = rand_coord(wide); it.cy = rand_coord(wide); it.cz = rand_coord(wide);
    it.last = last; it.drain = drain;
    vertex_q.push_back(it);
    n_items++;
  endtask

  // One element: vertices in order, some replaced by noise indexes
  task automatic add_element(logic [1:0] m, logic signed [17:0] a, b, c, bit wide,
                             bit noisy, bit drain);
    int cnt;
    logic [2:0] v;
    cnt = (m == ModeHex) ? 8 : (m == ModePrism) ? 6 : (m == ModePyramid) ? 5 :
          $urandom_range(1, 8);
    for (int k = 0; k < cnt; k++) begin
      v = 3'(k);
      if (noisy && $urandom_range(0, 9) == 0) v = 3'($urandom);
      add_vertex(m, v, a, b, c, wide, k == cnt - 1, drain && k == 0);
    end
  endtask

  function automatic logic signed [17:0] rand_eta();
    if ($urandom_range(0, 9) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 131072)) - 32'sd65536);
  endfunction

  // Stimulus
  initial begin
    jac_sums = '{default: 0};
    add_element(ModeHex, 18'sd0, 18'sd0, 18'sd0, 1'b0, 1'b0, 1'b0);
    add_element(ModeHex, 18'sd65536, -18'sd65536, 18'sd65536, 1'b1, 1'b0, 1'b0);
    add_element(ModePrism, -18'sd65536, 18'sd65536, -18'sd65536, 1'b0, 1'b0, 1'b0);
    add_element(ModePyramid, 18'sd131071, -18'sd131072, 18'sd32768, 1'b1, 1'b0, 1'b0);
    add_element(ModeReserved, 18'sd100, 18'sd200, 18'sd300, 1'b0, 1'b0, 1'b1);
    // two out-of-range vertices, then the apex closes a three-vertex element
    add_vertex(ModePyramid, 3'd7, 18'sd0, 18'sd0, 18'sd0, 1'b1, 1'b0, 1'b0);
    add_vertex(ModePrism, 3'd6, 18'sd0, 18'sd0, 18'sd0, 1'b1, 1'b0, 1'b0);
    add_vertex(ModePyramid, 3'd4, 18'sd0, 18'sd0, 18'sd0, 1'b1, 1'b1, 1'b0);
    while (n_items < 950) begin
      add_element($urandom_range(0, 19) == 0 ? ModeReserved : 2'($urandom_range(0, 2)),
                  rand_eta(), rand_eta(), rand_eta(), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 4) == 0, $urandom_range(0, 29) == 0);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (vertex_q.size() == 0 && !in_valid_i && det_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && det_q.size() == 0) begin
      $display("tb_element_jacobian_determinant: PASS");
    end else begin
      $display("tb_element_jacobian_determinant: FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_element_jacobian_determinant: FAIL");
    $finish;
  end

  // Driver: new transfer only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      out_stall_i <= (cyc < QuietStart || cyc > QuietEnd) && $urandom_range(0, 99) < 14;
      if (!in_valid_i || taken) begin
        taken = 1'b0;
        if (vertex_q.size() != 0 && !(vertex_q[0].drain && det_q.size() != 0) &&
            !((cyc < QuietStart || cyc > QuietEnd) && $urandom_range(0, 99) < 14)) begin
          cur_vertex = vertex_q.pop_front();
          in_valid_i     <= 1'b1;
          mode_i         <= cur_vertex.mode;
          vertex_index_i <= cur_vertex.vtx;
          eta_one_i      <= cur_vertex.e1;
          eta_two_i      <= cur_vertex.e2;
          eta_three_i    <= cur_vertex.e3;
          coord_x_i      <= cur_vertex.cx;
          coord_y_i      <= cur_vertex.cy;
          coord_z_i      <= cur_vertex.cz;
          last_vertex_i  <= cur_vertex.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    det_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_vertex(cur_vertex);
        taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (det_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result det=%h sat=%b", determinant_o, saturated_o);
        end else begin
          want = det_q.pop_front();
          if (determinant_o !== want.det || saturated_o !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: det exp %h got %h, sat exp %b got %b",
                       want.det, determinant_o, want.sat, saturated_o);
          end
        end
      end
    end
  end

endmodule
